// ----- rtl/addressed_frame_receiver_core_assert.svh -----
// Assertion macros used by the frame receiver controller (afr_ctrl).
`ifndef ADDRESSED_FRAME_RECEIVER_CORE_ASSERT_SVH
`define ADDRESSED_FRAME_RECEIVER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Implication checked in the same cycle.
`define AFR_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the cycle after the antecedent.
`define AFR_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AFR_ASSERT_IMP(name, clk, rstn, ante, cons, msg)
`define AFR_ASSERT_NXT(name, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/afr_pkg.sv -----
// Types and constants of the addressed frame receiver.
package afr_pkg;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    localparam logic [15:0] GAP_MAX   = 16'hFFFF;
    localparam logic [19:0] STALE_MAX = 20'hFFFFF;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_ELEMENTS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT   = 3'd4;

    localparam logic [7:0]  RST_OWN_ID        = 8'd0;
    localparam logic [4:0]  RST_ELEMENT_COUNT = 5'd8;
    localparam logic        RST_WIDE_ELEMENTS = 1'b1;
    localparam logic [15:0] RST_GAP_LIMIT     = 16'd20;
    localparam logic [19:0] RST_STALE_LIMIT   = 20'd30000;

    typedef enum logic [1:0] {
        STS_ELEM   = 2'd0,
        STS_REJECT = 2'd1,
        STS_STALE  = 2'd2
    } afr_status_t;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SENDER,
        PH_AT,
        PH_TARGET,
        PH_HASH2,
        PH_PAYLOAD,
        PH_TRAILER
    } afr_phase_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_READ,
        SEQ_PUSH,
        SEQ_STALE
    } afr_seq_t;

    typedef struct packed {
        logic [7:0]  own_id;
        logic [4:0]  element_count;
        logic        wide_elements;
        logic [15:0] gap_limit;
        logic [19:0] stale_limit;
    } afr_cfg_t;

    typedef struct packed {
        afr_status_t status;
        logic [3:0]  elem_index;
        logic [15:0] elem_value;
        logic        last;
    } afr_result_t;

endpackage

// ----- rtl/afr_stage_ram.sv -----
// Staging memory for payload elements, one write and one registered read port.
module afr_stage_ram #(
    parameter int   DEPTH = 16,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Hold the read data until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/afr_out_fifo.sv -----
// Two-entry result buffer between the frame sequencer and the result channel.
module afr_out_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    input  afr_pkg::afr_result_t push_data,
    output logic                 full,
    output logic                 m_valid,
    input  logic                 m_ready,
    output afr_pkg::afr_result_t m_data
);
    import afr_pkg::*;

    afr_result_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != 2'd0);
    assign full    = (count_reg == 2'd2);
    assign m_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push_valid) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push_valid} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/afr_ctrl.sv -----
// Frame parser, tick counters and result sequencer of the frame receiver.
`include "addressed_frame_receiver_core_assert.svh"

module afr_ctrl #(
    parameter int  MAX_ELEMENTS = 16,
    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  afr_pkg::afr_cfg_t    cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_func,
    input  logic [7:0]           s_rx_byte,
    output logic                 push_valid,
    output afr_pkg::afr_result_t push_data,
    input  logic                 fifo_full,
    output logic                 ram_we,
    output logic [AW-1:0]        ram_waddr,
    output logic [15:0]          ram_wdata,
    output logic                 ram_re,
    output logic [AW-1:0]        ram_raddr,
    input  logic [15:0]          ram_rdata
);
    import afr_pkg::*;

    localparam int EC_W = $clog2(MAX_ELEMENTS + 1);
    localparam int BC_W = EC_W + 1;

    afr_phase_t       phase_reg, phase_next;
    afr_seq_t         seq_reg, seq_next;
    logic             tm_reg, tm_next;
    logic [BC_W-1:0]  bc_reg, bc_next;
    logic [7:0]       low_reg, low_next;
    logic [15:0]      gap_reg, gap_next;
    logic [19:0]      stale_reg, stale_next;
    logic             stale_rep_reg, stale_rep_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [EC_W-1:0]  ec_reg, ec_next;

    logic             accept;
    logic             is_tick;
    logic             is_byte;
    logic [EC_W-1:0]  ec;
    logic [15:0]      gap_inc;
    logic [19:0]      stale_inc;
    logic             gap_abort;
    logic             stale_hit;
    logic             hdr_bad;
    logic             trl_ok;
    logic             trl_bad;
    logic             reject;
    logic [BC_W-1:0]  elem;
    logic             elem_ok;
    logic [BC_W-1:0]  bc_plus;
    logic [BC_W-1:0]  bc_target;
    logic             pay_byte;
    logic             last_elem;

    assign accept  = s_valid && s_ready;
    assign is_tick = accept && s_func;
    assign is_byte = accept && !s_func;

    // Clamp the element count into the supported range.
    always_comb begin
        if (cfg.element_count == 5'd0) begin
            ec = EC_W'(1);
        end else if (32'(cfg.element_count) > MAX_ELEMENTS) begin
            ec = EC_W'(MAX_ELEMENTS);
        end else begin
            ec = EC_W'(cfg.element_count);
        end
    end

    always_comb begin
        gap_inc   = (gap_reg == GAP_MAX) ? gap_reg : gap_reg + 16'd1;
        stale_inc = (stale_reg == STALE_MAX) ? stale_reg : stale_reg + 20'd1;
        gap_abort = is_tick && (phase_reg != PH_HUNT) && (gap_inc > cfg.gap_limit);
        stale_hit = is_tick && (stale_inc > cfg.stale_limit) && !stale_rep_reg;
        hdr_bad   = is_byte && (((phase_reg == PH_AT) && (s_rx_byte != CH_AT)) ||
                                ((phase_reg == PH_HASH2) && (s_rx_byte != CH_HASH)));
        trl_ok    = is_byte && (phase_reg == PH_TRAILER) && (s_rx_byte == CH_DOLLAR)
                    && tm_reg;
        trl_bad   = is_byte && (phase_reg == PH_TRAILER) && !trl_ok;
        reject    = gap_abort || hdr_bad || trl_bad;
        elem      = bc_reg >> cfg.wide_elements;
        elem_ok   = (elem < BC_W'(MAX_ELEMENTS));
        bc_plus   = bc_reg + BC_W'(1);
        bc_target = {1'b0, ec} << cfg.wide_elements;
        pay_byte  = is_byte && (phase_reg == PH_PAYLOAD);
        last_elem = (EC_W'(idx_reg) == (ec_reg - EC_W'(1)));
    end

    // Next state of the parser, the counters and the sequencer.
    always_comb begin
        phase_next     = phase_reg;
        seq_next       = seq_reg;
        tm_next        = tm_reg;
        bc_next        = bc_reg;
        low_next       = low_reg;
        gap_next       = gap_reg;
        stale_next     = stale_reg;
        stale_rep_next = stale_rep_reg;
        idx_next       = idx_reg;
        ec_next        = ec_reg;

        if (is_tick) begin
            if (phase_reg != PH_HUNT) begin
                gap_next = gap_inc;
            end
            if (gap_abort) begin
                phase_next = PH_HUNT;
            end
            stale_next = stale_inc;
            if (stale_hit) begin
                stale_rep_next = 1'b1;
            end
        end

        if (is_byte) begin
            gap_next = '0;
            case (phase_reg)
                PH_HUNT: begin
                    if (s_rx_byte == CH_HASH) begin
                        phase_next = PH_SENDER;
                    end
                end
                PH_SENDER: begin
                    phase_next = PH_AT;
                end
                PH_AT: begin
                    phase_next = hdr_bad ? PH_HUNT : PH_TARGET;
                end
                PH_TARGET: begin
                    tm_next    = (s_rx_byte == cfg.own_id);
                    phase_next = PH_HASH2;
                end
                PH_HASH2: begin
                    if (hdr_bad) begin
                        phase_next = PH_HUNT;
                    end else begin
                        bc_next    = '0;
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (cfg.wide_elements && !bc_reg[0]) begin
                        low_next = s_rx_byte;
                    end
                    bc_next = bc_plus;
                    if (bc_plus >= bc_target) begin
                        phase_next = PH_TRAILER;
                    end
                end
                PH_TRAILER: begin
                    if (trl_ok) begin
                        stale_next     = '0;
                        stale_rep_next = 1'b0;
                        ec_next        = ec;
                        idx_next       = '0;
                    end
                    phase_next = PH_HUNT;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        case (seq_reg)
            SEQ_IDLE: begin
                if (trl_ok) begin
                    seq_next = SEQ_READ;
                end else if (reject && stale_hit) begin
                    seq_next = SEQ_STALE;
                end
            end
            SEQ_READ: begin
                seq_next = SEQ_PUSH;
            end
            SEQ_PUSH: begin
                if (!fifo_full) begin
                    if (last_elem) begin
                        seq_next = SEQ_IDLE;
                    end else begin
                        idx_next = idx_reg + AW'(1);
                        seq_next = SEQ_READ;
                    end
                end
            end
            SEQ_STALE: begin
                if (!fifo_full) begin
                    seq_next = SEQ_IDLE;
                end
            end
            default: begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    // Handshake, result pushes and memory accesses.
    always_comb begin
        s_ready              = (seq_reg == SEQ_IDLE) && !fifo_full;
        push_valid           = 1'b0;
        push_data.status     = STS_REJECT;
        push_data.elem_index = '0;
        push_data.elem_value = '0;
        push_data.last       = 1'b1;

        case (seq_reg)
            SEQ_IDLE: begin
                if (reject) begin
                    push_valid = 1'b1;
                end else if (stale_hit) begin
                    push_valid       = 1'b1;
                    push_data.status = STS_STALE;
                end
            end
            SEQ_PUSH: begin
                push_valid           = !fifo_full;
                push_data.status     = STS_ELEM;
                push_data.elem_index = 4'(idx_reg);
                push_data.elem_value = ram_rdata;
                push_data.last       = last_elem;
            end
            SEQ_STALE: begin
                push_valid       = !fifo_full;
                push_data.status = STS_STALE;
            end
            default: begin
                push_valid = 1'b0;
            end
        endcase

        ram_re    = (seq_reg == SEQ_READ);
        ram_raddr = idx_reg;
        ram_we    = pay_byte && elem_ok && (!cfg.wide_elements || bc_reg[0]);
        ram_waddr = elem[AW-1:0];
        ram_wdata = cfg.wide_elements ? {s_rx_byte, low_reg} : {8'h00, s_rx_byte};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            seq_reg       <= SEQ_IDLE;
            tm_reg        <= 1'b0;
            bc_reg        <= '0;
            low_reg       <= '0;
            gap_reg       <= '0;
            stale_reg     <= '0;
            stale_rep_reg <= 1'b0;
            idx_reg       <= '0;
            ec_reg        <= EC_W'(1);
        end else begin
            phase_reg     <= phase_next;
            seq_reg       <= seq_next;
            tm_reg        <= tm_next;
            bc_reg        <= bc_next;
            low_reg       <= low_next;
            gap_reg       <= gap_next;
            stale_reg     <= stale_next;
            stale_rep_reg <= stale_rep_next;
            idx_reg       <= idx_next;
            ec_reg        <= ec_next;
        end
    end

    `AFR_ASSERT_IMP(a_push_room, aclk, aresetn, push_valid, !fifo_full, "push into full buffer")
    `AFR_ASSERT_IMP(a_no_write_in_run, aclk, aresetn, ram_we, seq_reg == SEQ_IDLE, "write in run")
    `AFR_ASSERT_NXT(a_run_start, aclk, aresetn, trl_ok, (seq_reg == SEQ_READ) && (idx_reg == '0), "bad run start")
    `AFR_ASSERT_IMP(a_push_after_read, aclk, aresetn, seq_reg == SEQ_PUSH, $past(seq_reg) == SEQ_READ || $past(seq_reg) == SEQ_PUSH, "push without read")
    `AFR_ASSERT_IMP(a_idx_range, aclk, aresetn, seq_reg == SEQ_READ || seq_reg == SEQ_PUSH, EC_W'(idx_reg) < ec_reg, "element index out of run")

endmodule

// ----- rtl/addressed_frame_receiver_core.sv -----
// Top level of the addressed frame receiver: registers, parser, staging memory, result buffer.
// A reject or stale result is visible on m_valid in the cycle after its item is taken.
// A good trailer starts a run of N elements, each read from the staging memory and then pushed,
// stalling while the buffer is full; no item is taken during the run or while a stale result
// waits behind a reject. Throughput: one byte or tick item per cycle otherwise, while the
// two-entry buffer has room. Reset: synchronous, active low; clears parser, counters, buffer and
// registers to defaults; the staging memory is not cleared and needs no clearing pass.
module addressed_frame_receiver_core #(
    parameter int MAX_ELEMENTS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [afr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [afr_pkg::CFG_DATA_W-1:0] cfg_data,
    // input item channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [7:0]                    s_rx_byte,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [3:0]                    m_elem_index,
    output logic [15:0]                   m_elem_value,
    output logic                          m_last
);
    import afr_pkg::*;

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    logic [7:0]  own_id_reg;
    logic [4:0]  element_count_reg;
    logic        wide_elements_reg;
    logic [15:0] gap_limit_reg;
    logic [19:0] stale_limit_reg;
    afr_cfg_t    cfg;

    logic        push_valid;
    afr_result_t push_data;
    logic        fifo_full;
    afr_result_t m_data;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    // Registers take a write in every cycle; writes beyond the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg        <= RST_OWN_ID;
            element_count_reg <= RST_ELEMENT_COUNT;
            wide_elements_reg <= RST_WIDE_ELEMENTS;
            gap_limit_reg     <= RST_GAP_LIMIT;
            stale_limit_reg   <= RST_STALE_LIMIT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_OWN_ID:        own_id_reg        <= cfg_data[7:0];
                CFG_ELEMENT_COUNT: element_count_reg <= cfg_data[4:0];
                CFG_WIDE_ELEMENTS: wide_elements_reg <= cfg_data[0];
                CFG_GAP_LIMIT:     gap_limit_reg     <= cfg_data[15:0];
                CFG_STALE_LIMIT:   stale_limit_reg   <= cfg_data[19:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.own_id        = own_id_reg;
    assign cfg.element_count = element_count_reg;
    assign cfg.wide_elements = wide_elements_reg;
    assign cfg.gap_limit     = gap_limit_reg;
    assign cfg.stale_limit   = stale_limit_reg;

    // Parse the frame, run the tick counters and sequence the results.
    afr_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_rx_byte  (s_rx_byte),
        .push_valid (push_valid),
        .push_data  (push_data),
        .fifo_full  (fifo_full),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    // Hold payload elements until the trailer decides the frame.
    afr_stage_ram #(
        .DEPTH (MAX_ELEMENTS)
    ) u_stage_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decouple the result channel so items keep flowing while a result waits.
    afr_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (fifo_full),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    assign m_status     = m_data.status;
    assign m_elem_index = m_data.elem_index;
    assign m_elem_value = m_data.elem_value;
    assign m_last       = m_data.last;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for addressed_frame_receiver_core: directed rows, then random frames.
`timescale 1ns / 100ps

module tb;
    import afr_pkg::*;

    localparam int MAX_ELEM = 16;

    // func field of an input item
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // shapes of a generated frame
    localparam int FRAME_OK       = 0;
    localparam int FRAME_BAD_AT   = 1;
    localparam int FRAME_BAD_HASH = 2;

    // how a row's results are known: from the predictor, or typed into the row
    typedef enum logic [1:0] {
        CHK_PRED,
        CHK_QUIET,
        CHK_REJECT,
        CHK_ELEM
    } chk_t;

    typedef struct packed {
        logic        func;
        logic [7:0]  rx_byte;
        chk_t        chk;
        logic [15:0] val;
    } stim_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_func;
    logic [7:0]            s_rx_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_status;
    logic [3:0]            m_elem_index;
    logic [15:0]           m_elem_value;
    logic                  m_last;

    addressed_frame_receiver_core #(
        .MAX_ELEMENTS(MAX_ELEM)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_elem_index (m_elem_index),
        .m_elem_value (m_elem_value),
        .m_last       (m_last)
    );

    // Receiver shadow: registers and parser state as the block should hold them.
    afr_cfg_t    regs;
    afr_phase_t  rx_phase;
    logic        tgt_hit;
    logic [5:0]  byte_cnt;
    logic [7:0]  low_hold;
    logic [15:0] stage_mem [MAX_ELEM];
    logic [15:0] gap_cnt;
    logic [19:0] stale_cnt;
    logic        stale_done;

    afr_result_t step_results[$];     // results of the item just taken
    afr_result_t awaited_results[$];  // results still due on the m_ channel

    stim_t dir_rows [27];
    stim_t cur_item;                  // item currently presented on the s_ channel
    bit    idle_en;
    int    hold_cycles;
    int    fail_count;
    int    items_taken;
    int    work_items;                // items the parser does not simply ignore
    int    results_seen;
    int    n_elem;
    int    n_reject;
    int    n_stale;

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (fail_count < 40) $display("MISMATCH at %0t: %s", $time, what);
        fail_count++;
    endtask

    function automatic afr_result_t mk_result(input afr_status_t st, input logic [3:0] idx,
                                              input logic [15:0] val, input logic lst);
        afr_result_t r;
        r.status     = st;
        r.elem_index = idx;
        r.elem_value = val;
        r.last       = lst;
        return r;
    endfunction

    function automatic stim_t mk_row(input logic func, input logic [7:0] b, input chk_t chk,
                                     input logic [15:0] val);
        stim_t r;
        r.func    = func;
        r.rx_byte = b;
        r.chk     = chk;
        r.val     = val;
        return r;
    endfunction

    // Element count as the parser uses it: clamp into 1..MAX_ELEM.
    function automatic int eff_count();
        if (regs.element_count == 0) return 1;
        if (regs.element_count > MAX_ELEM) return MAX_ELEM;
        return int'(regs.element_count);
    endfunction

    function automatic void receiver_reset();
        regs.own_id        = RST_OWN_ID;
        regs.element_count = RST_ELEMENT_COUNT;
        regs.wide_elements = RST_WIDE_ELEMENTS;
        regs.gap_limit     = RST_GAP_LIMIT;
        regs.stale_limit   = RST_STALE_LIMIT;
        rx_phase   = PH_HUNT;
        tgt_hit    = 1'b0;
        byte_cnt   = '0;
        low_hold   = '0;
        gap_cnt    = '0;
        stale_cnt  = '0;
        stale_done = 1'b0;
        foreach (stage_mem[i]) stage_mem[i] = '0;
    endfunction

    // Advance the receiver shadow by one item and collect what it emits.
    function automatic void receive_step(input logic func, input logic [7:0] b);
        int elem;
        int ec;
        step_results.delete();
        if (func == FUNC_TICK) begin
            // ticks inside a frame run the byte-gap watchdog
            if (rx_phase != PH_HUNT) begin
                if (gap_cnt != GAP_MAX) gap_cnt++;
                if (gap_cnt > regs.gap_limit) begin
                    step_results.push_back(mk_result(STS_REJECT, 4'd0, 16'd0, 1'b1));
                    rx_phase = PH_HUNT;
                end
            end
            // stale report fires once until a good frame re-arms it
            if (stale_cnt != STALE_MAX) stale_cnt++;
            if (stale_cnt > regs.stale_limit && !stale_done) begin
                step_results.push_back(mk_result(STS_STALE, 4'd0, 16'd0, 1'b1));
                stale_done = 1'b1;
            end
            return;
        end
        gap_cnt = '0;
        case (rx_phase)
            PH_HUNT: begin
                if (b == CH_HASH) rx_phase = PH_SENDER;
            end
            PH_SENDER: begin
                rx_phase = PH_AT;
            end
            PH_AT: begin
                if (b == CH_AT) begin
                    rx_phase = PH_TARGET;
                end else begin
                    step_results.push_back(mk_result(STS_REJECT, 4'd0, 16'd0, 1'b1));
                    rx_phase = PH_HUNT;
                end
            end
            PH_TARGET: begin
                tgt_hit  = (b == regs.own_id);
                rx_phase = PH_HASH2;
            end
            PH_HASH2: begin
                if (b == CH_HASH) begin
                    byte_cnt = '0;
                    rx_phase = PH_PAYLOAD;
                end else begin
                    step_results.push_back(mk_result(STS_REJECT, 4'd0, 16'd0, 1'b1));
                    rx_phase = PH_HUNT;
                end
            end
            PH_PAYLOAD: begin
                elem = int'(byte_cnt) >> regs.wide_elements;
                if (elem < MAX_ELEM) begin
                    if (regs.wide_elements) begin
                        // little endian: hold the low byte until its partner arrives
                        if (byte_cnt[0]) stage_mem[elem] = {b, low_hold};
                        else low_hold = b;
                    end else begin
                        stage_mem[elem] = {8'h00, b};
                    end
                end
                byte_cnt++;
                if (int'(byte_cnt) >= (eff_count() << regs.wide_elements))
                    rx_phase = PH_TRAILER;
            end
            PH_TRAILER: begin
                if (b == CH_DOLLAR && tgt_hit) begin
                    ec = eff_count();
                    for (int i = 0; i < ec; i++) begin
                        step_results.push_back(mk_result(STS_ELEM, 4'(i), stage_mem[i],
                                                         i == ec - 1));
                    end
                    stale_cnt  = '0;
                    stale_done = 1'b0;
                end else begin
                    step_results.push_back(mk_result(STS_REJECT, 4'd0, 16'd0, 1'b1));
                end
                rx_phase = PH_HUNT;
            end
            default: begin
                rx_phase = PH_HUNT;
            end
        endcase
    endfunction

    // Sample the result, item and configuration channels at the rising edge: check results first, then predict.
    always @(posedge aclk) begin : scoreboard
        afr_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing awaited (status %0d)",
                                          m_status));
            end else begin
                want = awaited_results.pop_front();
                case (want.status)
                    STS_ELEM:   n_elem++;
                    STS_REJECT: n_reject++;
                    default:    n_stale++;
                endcase
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", m_status, want.status));
                if (m_elem_index !== want.elem_index)
                    report_mismatch($sformatf("elem_index %0d, want %0d",
                                              m_elem_index, want.elem_index));
                if (m_elem_value !== want.elem_value)
                    report_mismatch($sformatf("elem_value %h, want %h",
                                              m_elem_value, want.elem_value));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", m_last, want.last));
            end
        end
        if (aresetn && s_valid && s_ready) begin
            items_taken++;
            if (!(cur_item.func == FUNC_BYTE && rx_phase == PH_HUNT &&
                  cur_item.rx_byte != CH_HASH))
                work_items++;
            receive_step(cur_item.func, cur_item.rx_byte);
            // typed rows stand in for the predictor on their own item
            case (cur_item.chk)
                CHK_PRED:   foreach (step_results[i]) awaited_results.push_back(step_results[i]);
                CHK_QUIET:  ;
                CHK_REJECT: awaited_results.push_back(mk_result(STS_REJECT, 4'd0, 16'd0, 1'b1));
                default:    awaited_results.push_back(mk_result(STS_ELEM, 4'd0, cur_item.val,
                                                                1'b1));
            endcase
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_OWN_ID:        regs.own_id        = cfg_data[7:0];
                CFG_ELEMENT_COUNT: regs.element_count = cfg_data[4:0];
                CFG_WIDE_ELEMENTS: regs.wide_elements = cfg_data[0];
                CFG_GAP_LIMIT:     regs.gap_limit     = cfg_data[15:0];
                CFG_STALE_LIMIT:   regs.stale_limit   = cfg_data[19:0];
                default:           ;
            endcase
        end
    end

    // Result side back-pressure: random stall bursts of random length while idle_en is set.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready     <= 1'b0;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            hold_cycles <= $urandom_range(0, 8);
            m_ready     <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Present one item at the falling edge and hold it until taken.
    // Returns at the falling edge after the handshake with s_valid still high;
    // the caller either presents the next item or drops s_valid in that same step.
    task automatic send_item(input stim_t it);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= it.func;
        s_rx_byte <= it.rx_byte;
        cur_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(mk_row(FUNC_BYTE, b, CHK_PRED, 16'd0));
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(mk_row(FUNC_TICK, 8'h00, CHK_PRED, 16'd0));
    endtask

    // Write one register, leaving cfg_valid high for the next write; program_regs drops it afterward.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Program every register; unused upper data bits carry random junk.
    task automatic program_regs(input logic [7:0] own, input logic [4:0] count,
                                input logic wide, input logic [15:0] gap,
                                input logic [19:0] stale);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_OWN_ID,        {junk[11:0], own});
        write_reg(CFG_ELEMENT_COUNT, {junk[14:0], count});
        write_reg(CFG_WIDE_ELEMENTS, {junk[18:0], wide});
        write_reg(CFG_GAP_LIMIT,     {junk[3:0], gap});
        write_reg(CFG_STALE_LIMIT,   stale);
        cfg_valid <= 1'b0;
    endtask

    // Push filler bytes until the parser is back to hunting, so no register
    // change ever lands inside a frame.
    task automatic flush_frame();
        while (rx_phase != PH_HUNT) send_byte(8'h00);
        s_valid <= 1'b0;
    endtask

    // Wait for every awaited result, then give the block time to settle.
    task automatic drain();
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Occasionally stall the byte stream inside a frame; short limits get
    // bursts long enough to trip the gap watchdog.
    task automatic maybe_gap();
        if ($urandom_range(0, 9) == 0) begin
            if (regs.gap_limit < 12) send_ticks($urandom_range(1, int'(regs.gap_limit) + 1));
            else send_ticks($urandom_range(1, 4));
        end
    endtask

    task automatic send_frame(input int shape);
        logic [7:0] b;
        int         nbytes;
        nbytes = eff_count() << regs.wide_elements;
        send_byte(CH_HASH);
        maybe_gap();
        send_byte(8'($urandom));                   // sender id: anything goes
        maybe_gap();
        if (shape == FRAME_BAD_AT) begin
            b = 8'($urandom);
            if (b == CH_AT) b = ~b;
            send_byte(b);
            return;
        end
        send_byte(CH_AT);
        maybe_gap();
        // mostly addressed to us, sometimes to a random station
        send_byte(($urandom_range(0, 3) != 0) ? regs.own_id : 8'($urandom));
        maybe_gap();
        if (shape == FRAME_BAD_HASH) begin
            b = 8'($urandom);
            if (b == CH_HASH) b = ~b;
            send_byte(b);
            return;
        end
        send_byte(CH_HASH);
        for (int i = 0; i < nbytes; i++) begin
            maybe_gap();
            // delimiters inside the payload are plain data
            case ($urandom_range(0, 15))
                0:       send_byte(CH_HASH);
                1:       send_byte(CH_DOLLAR);
                default: send_byte(8'($urandom));
            endcase
        end
        maybe_gap();
        send_byte(($urandom_range(0, 7) != 0) ? CH_DOLLAR : 8'($urandom));
    endtask

    // Mostly well-formed frames with random content; the rest is broken
    // headers, line noise and runs of idle ticks that push toward stale.
    task automatic random_traffic(input int budget);
        int start;
        int pick;
        start = work_items;
        while (work_items - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame(FRAME_OK);
            end else if (pick < 80) begin
                send_frame(pick[0] ? FRAME_BAD_AT : FRAME_BAD_HASH);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else if (regs.stale_limit < 64) begin
                send_ticks($urandom_range(1, int'(regs.stale_limit) / 2 + 2));
            end else begin
                send_ticks($urandom_range(1, 5));
            end
        end
    endtask

    initial begin
        // drive every input known from time zero
        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_OWN_ID;
        cfg_data    <= '0;
        s_valid     <= 1'b0;
        s_func      <= FUNC_BYTE;
        s_rx_byte   <= 8'h00;
        m_ready     <= 1'b0;
        cur_item    <= mk_row(FUNC_BYTE, 8'h00, CHK_PRED, 16'd0);
        idle_en      = 1'b1;
        hold_cycles  = 0;
        fail_count   = 0;
        items_taken  = 0;
        work_items   = 0;
        results_seen = 0;
        n_elem       = 0;
        n_reject     = 0;
        n_stale      = 0;
        receiver_reset();

        // Directed rows run with own id 0x5A, element count 0 (clamps to one byte),
        // gap limit 1 and stale limit 2, so every special case fits in a few items.
        dir_rows = '{
            mk_row(FUNC_BYTE, 8'h00,     CHK_QUIET,  16'h0000),  // ignored while hunting
            mk_row(FUNC_TICK, 8'h00,     CHK_QUIET,  16'h0000),  // stale count 1
            mk_row(FUNC_BYTE, CH_HASH,   CHK_QUIET,  16'h0000),
            mk_row(FUNC_BYTE, 8'hFF,     CHK_QUIET,  16'h0000),  // sender
            mk_row(FUNC_BYTE, 8'h00,     CHK_REJECT, 16'h0000),  // no '@'
            mk_row(FUNC_BYTE, CH_HASH,   CHK_QUIET,  16'h0000),
            mk_row(FUNC_BYTE, 8'h00,     CHK_QUIET,  16'h0000),
            mk_row(FUNC_BYTE, CH_AT,     CHK_QUIET,  16'h0000),
            mk_row(FUNC_BYTE, 8'hFF,     CHK_QUIET,  16'h0000),  // foreign target
            mk_row(FUNC_BYTE, CH_HASH,   CHK_QUIET,  16'h0000),
            mk_row(FUNC_BYTE, 8'hFF,     CHK_QUIET,  16'h0000),  // payload
            mk_row(FUNC_BYTE, CH_DOLLAR, CHK_REJECT, 16'h0000),  // good trailer, wrong target
            mk_row(FUNC_BYTE, CH_HASH,   CHK_QUIET,  16'h0000),
            mk_row(FUNC_BYTE, 8'h80,     CHK_QUIET,  16'h0000),
            mk_row(FUNC_BYTE, CH_AT,     CHK_QUIET,  16'h0000),
            mk_row(FUNC_BYTE, 8'h5A,     CHK_QUIET,  16'h0000),
            mk_row(FUNC_BYTE, 8'h00,     CHK_REJECT, 16'h0000),  // no closing '#'
            mk_row(FUNC_BYTE, CH_HASH,   CHK_QUIET,  16'h0000),
            mk_row(FUNC_TICK, 8'h00,     CHK_QUIET,  16'h0000),  // gap 1, still legal
            mk_row(FUNC_TICK, 8'h00,     CHK_PRED,   16'h0000),  // gap abort, then stale
            mk_row(FUNC_BYTE, CH_HASH,   CHK_PRED,   16'h0000),
            mk_row(FUNC_BYTE, 8'h01,     CHK_PRED,   16'h0000),
            mk_row(FUNC_BYTE, CH_AT,     CHK_PRED,   16'h0000),
            mk_row(FUNC_BYTE, 8'h5A,     CHK_PRED,   16'h0000),
            mk_row(FUNC_BYTE, CH_HASH,   CHK_PRED,   16'h0000),
            mk_row(FUNC_BYTE, 8'hFF,     CHK_QUIET,  16'h0000),
            mk_row(FUNC_BYTE, CH_DOLLAR, CHK_ELEM,   16'h00FF)   // accepted frame
        };

        // hold reset low, then release it at a falling edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        program_regs(8'h5A, 5'd0, 1'b0, 16'd1, 20'd2);
        foreach (dir_rows[i]) send_item(dir_rows[i]);
        flush_frame();
        drain();

        // widest limits: no abort and no stale report can fire
        program_regs(8'h00, 5'd1, 1'b1, 16'hFFFF, 20'hFFFFF);
        random_traffic(20);
        flush_frame();
        drain();

        // count above range clamps to sixteen byte elements
        program_regs(8'hFF, 5'd31, 1'b0, 16'd3, 20'd40);
        random_traffic(20);
        flush_frame();
        drain();

        // largest frame: sixteen wide elements; stale on the first idle tick
        program_regs(8'($urandom), 5'd16, 1'b1, 16'd2, 20'd0);
        random_traffic(20);
        flush_frame();
        drain();

        // any tick inside a frame aborts it
        program_regs(8'($urandom), 5'($urandom_range(1, 4)), 1'($urandom), 16'd0,
                     20'($urandom_range(1, 20)));
        random_traffic(20);
        flush_frame();
        drain();

        // final stretch runs with both sides always ready
        idle_en = 1'b0;
        program_regs(8'($urandom), 5'($urandom_range(1, 3)), 1'($urandom),
                     16'($urandom_range(2, 10)), 20'($urandom_range(5, 30)));
        random_traffic(20);
        flush_frame();
        drain();

        $display("summary: %0d items taken (%0d reached the parser), six register settings",
                 items_taken, work_items);
        $display("summary: %0d results checked: %0d elements, %0d rejects, %0d stale",
                 results_seen, n_elem, n_reject, n_stale);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
